// File: rtl/core/bba_pkg.sv
// shared types, command codes and attack helper functions for the attack generator
// no dependencies; used by every module under rtl/core
package bba_pkg;

  // command codes of a transaction
  typedef enum logic [2:0] {
    CmdKing       = 3'd0,
    CmdKnight     = 3'd1,
    CmdRook       = 3'd2,
    CmdBishop     = 3'd3,
    CmdRookXray   = 3'd4,
    CmdBishopXray = 3'd5
  } cmd_e;

  localparam int unsigned SqW    = 6;
  localparam int unsigned BoardW = 64;

  // control that travels down the pipeline with each transaction
  typedef struct packed {
    logic             valid;
    logic [2:0]       cmd;
    logic [SqW-1:0]   square;
    logic             diag;
  } ctl_t;

  // leaper step tables
  localparam int KingDf[8]   = '{ 1,  1,  0, -1, -1, -1,  0,  1};
  localparam int KingDr[8]   = '{ 0,  1,  1,  1,  0, -1, -1, -1};
  localparam int KnightDf[8] = '{ 1,  2,  2,  1, -1, -2, -2, -1};
  localparam int KnightDr[8] = '{ 2,  1, -1, -2, -2, -1,  1,  2};

  // slider ray directions
  localparam int RookDf[4]   = '{ 1, -1,  0,  0};
  localparam int RookDr[4]   = '{ 0,  0,  1, -1};
  localparam int BishopDf[4] = '{ 1,  1, -1, -1};
  localparam int BishopDr[4] = '{ 1, -1,  1, -1};

  // king or knight attacks from one square, clipped at the board edges
  function automatic logic [BoardW-1:0] leaper_attacks(
    input logic [SqW-1:0] sq,
    input logic           knight
  );
    logic [BoardW-1:0] a;
    int                f;
    int                r;
    a = '0;
    for (int i = 0; i < 8; i++) begin
      f = int'(sq[2:0]) + (knight ? KnightDf[i] : KingDf[i]);
      r = int'(sq[5:3]) + (knight ? KnightDr[i] : KingDr[i]);
      if (f >= 0 && f <= 7 && r >= 0 && r <= 7) begin
        a[SqW'(r * 8 + f)] = 1'b1;
      end
    end
    return a;
  endfunction

  // four independent rays of up to seven steps, each ending on its first blocker
  function automatic logic [BoardW-1:0] slider_attacks(
    input logic [SqW-1:0]    sq,
    input logic [BoardW-1:0] occ,
    input logic              diag
  );
    logic [BoardW-1:0] a;
    logic              stop;
    int                f;
    int                r;
    int                df;
    int                dr;
    a = '0;
    for (int d = 0; d < 4; d++) begin
      df   = diag ? BishopDf[d] : RookDf[d];
      dr   = diag ? BishopDr[d] : RookDr[d];
      f    = int'(sq[2:0]);
      r    = int'(sq[5:3]);
      stop = 1'b0;
      for (int s = 0; s < 7; s++) begin
        f = f + df;
        r = r + dr;
        if (f < 0 || f > 7 || r < 0 || r > 7) begin
          stop = 1'b1;
        end else if (!stop) begin
          a[SqW'(r * 8 + f)] = 1'b1;
          if (occ[SqW'(r * 8 + f)]) begin
            stop = 1'b1;
          end
        end
      end
    end
    return a;
  endfunction

endpackage

// File: rtl/core/bba_decode.sv
// first pipeline stage: captures a transaction, decodes the command, forms leaper attacks
// depends on bba_pkg
module bba_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [2:0]                  cmd_i,
  input  logic [bba_pkg::SqW-1:0]     square_i,
  input  logic [bba_pkg::BoardW-1:0]  occupancy_i,
  input  logic [bba_pkg::BoardW-1:0]  xray_blockers_i,
  output bba_pkg::ctl_t               ctl_o,
  output logic [bba_pkg::BoardW-1:0]  occ_o,
  output logic [bba_pkg::BoardW-1:0]  blk_o,
  output logic [bba_pkg::BoardW-1:0]  leap_o
);

  logic                       valid_q;
  logic [2:0]                 cmd_q;
  logic [bba_pkg::SqW-1:0]    square_q;
  logic                       diag_q;
  logic                       diag_d;
  logic [bba_pkg::BoardW-1:0] occ_q;
  logic [bba_pkg::BoardW-1:0] blk_q;
  logic [bba_pkg::BoardW-1:0] leap_q;
  logic [bba_pkg::BoardW-1:0] leap_d;

  // command decode and leaper attacks
  always_comb begin
    diag_d = 1'b0;
    leap_d = '0;
    unique case (bba_pkg::cmd_e'(cmd_i))
      bba_pkg::CmdKing:       leap_d = bba_pkg::leaper_attacks(square_i, 1'b0);
      bba_pkg::CmdKnight:     leap_d = bba_pkg::leaper_attacks(square_i, 1'b1);
      bba_pkg::CmdBishop,
      bba_pkg::CmdBishopXray: diag_d = 1'b1;
      default:                diag_d = 1'b0;
    endcase
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd_q    <= cmd_i;
      square_q <= square_i;
      diag_q   <= diag_d;
      occ_q    <= occupancy_i;
      blk_q    <= xray_blockers_i;
      leap_q   <= leap_d;
    end
  end

  assign ctl_o  = '{valid: valid_q, cmd: cmd_q, square: square_q, diag: diag_q};
  assign occ_o  = occ_q;
  assign blk_o  = blk_q;
  assign leap_o = leap_q;

endmodule

// File: rtl/core/bba_scan.sv
// second pipeline stage: first slider ray scan over the given occupancy
// depends on bba_pkg
module bba_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bba_pkg::ctl_t               ctl_i,
  input  logic [bba_pkg::BoardW-1:0]  occ_i,
  input  logic [bba_pkg::BoardW-1:0]  blk_i,
  input  logic [bba_pkg::BoardW-1:0]  leap_i,
  output bba_pkg::ctl_t               ctl_o,
  output logic [bba_pkg::BoardW-1:0]  occ_o,
  output logic [bba_pkg::BoardW-1:0]  blk_o,
  output logic [bba_pkg::BoardW-1:0]  leap_o,
  output logic [bba_pkg::BoardW-1:0]  atk_o
);

  logic                       valid_q;
  bba_pkg::ctl_t              ctl_q;
  logic [bba_pkg::BoardW-1:0] occ_q;
  logic [bba_pkg::BoardW-1:0] blk_q;
  logic [bba_pkg::BoardW-1:0] leap_q;
  logic [bba_pkg::BoardW-1:0] atk_q;
  logic [bba_pkg::BoardW-1:0] atk_d;

  // slider attacks on the original occupancy
  assign atk_d = bba_pkg::slider_attacks(ctl_i.square, occ_i, ctl_i.diag);

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      ctl_q  <= ctl_i;
      occ_q  <= occ_i;
      blk_q  <= blk_i;
      leap_q <= leap_i;
      atk_q  <= atk_d;
    end
  end

  assign ctl_o  = '{valid: valid_q, cmd: ctl_q.cmd, square: ctl_q.square, diag: ctl_q.diag};
  assign occ_o  = occ_q;
  assign blk_o  = blk_q;
  assign leap_o = leap_q;
  assign atk_o  = atk_q;

endmodule

// File: rtl/core/bba_xray.sv
// third pipeline stage: second ray scan with hit blockers toggled, result select
// depends on bba_pkg
module bba_xray (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bba_pkg::ctl_t               ctl_i,
  input  logic [bba_pkg::BoardW-1:0]  occ_i,
  input  logic [bba_pkg::BoardW-1:0]  blk_i,
  input  logic [bba_pkg::BoardW-1:0]  leap_i,
  input  logic [bba_pkg::BoardW-1:0]  atk_i,
  output logic                        done_o,
  output logic [bba_pkg::BoardW-1:0]  attack_set_o
);

  logic                       done_q;
  logic [bba_pkg::BoardW-1:0] result_q;
  logic [bba_pkg::BoardW-1:0] result_d;
  logic [bba_pkg::BoardW-1:0] occ_x;
  logic [bba_pkg::BoardW-1:0] atk_x;

  // rescan with the blockers that the first scan hit toggled in the occupancy
  assign occ_x = occ_i ^ (blk_i & atk_i);
  assign atk_x = bba_pkg::slider_attacks(ctl_i.square, occ_x, ctl_i.diag);

  // result select per command
  always_comb begin
    unique case (bba_pkg::cmd_e'(ctl_i.cmd))
      bba_pkg::CmdKing,
      bba_pkg::CmdKnight:     result_d = leap_i;
      bba_pkg::CmdRook,
      bba_pkg::CmdBishop:     result_d = atk_i;
      bba_pkg::CmdRookXray,
      bba_pkg::CmdBishopXray: result_d = atk_i ^ atk_x;
      default:                result_d = '0;
    endcase
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.valid;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      result_q <= result_d;
    end
  end

  assign done_o       = done_q;
  assign attack_set_o = result_q;

endmodule

// File: rtl/core/bitboard_attack_generator_top.sv
// top level of the chess attack-set generator: three register stages in a row
// depends on bba_pkg, bba_decode, bba_scan, bba_xray
//
// One transaction is taken on every clock edge where start is high; busy
// stays low, so a new query may follow in the next cycle without limit. Each
// query gives exactly one attack set on attack_set_o, marked by a one-cycle
// done_o strobe, in the order the queries came. The query passes through
// three registered stages in turn: command decode with king and knight
// attacks, the first rook or bishop ray scan, and the x-ray rescan with result
// select. The receiver cannot hold results off and must take each one as it
// appears. Command codes 6 and 7 return an empty set.
module bitboard_attack_generator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  cmd_i,
  input  logic [bba_pkg::SqW-1:0]     square_i,
  input  logic [bba_pkg::BoardW-1:0]  occupancy_i,
  input  logic [bba_pkg::BoardW-1:0]  xray_blockers_i,
  output logic                        done_o,
  output logic [bba_pkg::BoardW-1:0]  attack_set_o
);

  bba_pkg::ctl_t              dec_ctl;
  logic [bba_pkg::BoardW-1:0] dec_occ;
  logic [bba_pkg::BoardW-1:0] dec_blk;
  logic [bba_pkg::BoardW-1:0] dec_leap;
  bba_pkg::ctl_t              scn_ctl;
  logic [bba_pkg::BoardW-1:0] scn_occ;
  logic [bba_pkg::BoardW-1:0] scn_blk;
  logic [bba_pkg::BoardW-1:0] scn_leap;
  logic [bba_pkg::BoardW-1:0] scn_atk;
  logic                       accept;

  // every stage advances each cycle, so the block is never busy
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: decode and leaper attacks
  bba_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .cmd_i           (cmd_i),
    .square_i        (square_i),
    .occupancy_i     (occupancy_i),
    .xray_blockers_i (xray_blockers_i),
    .ctl_o           (dec_ctl),
    .occ_o           (dec_occ),
    .blk_o           (dec_blk),
    .leap_o          (dec_leap)
  );

  // stage 2: first ray scan
  bba_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dec_ctl),
    .occ_i  (dec_occ),
    .blk_i  (dec_blk),
    .leap_i (dec_leap),
    .ctl_o  (scn_ctl),
    .occ_o  (scn_occ),
    .blk_o  (scn_blk),
    .leap_o (scn_leap),
    .atk_o  (scn_atk)
  );

  // stage 3: x-ray rescan and result register
  bba_xray u_xray (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (scn_ctl),
    .occ_i        (scn_occ),
    .blk_i        (scn_blk),
    .leap_i       (scn_leap),
    .atk_i        (scn_atk),
    .done_o       (done_o),
    .attack_set_o (attack_set_o)
  );

endmodule

// File: test/bitboard_attack_generator_checker.sv
// scoreboard for the attack generator: predicts each attack set and compares results
// depends on bba_pkg for the command codes and board widths
module bitboard_attack_generator_checker
  import bba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic [2:0]        cmd_i,
  input  logic [SqW-1:0]    square_i,
  input  logic [BoardW-1:0] occupancy_i,
  input  logic [BoardW-1:0] xray_blockers_i,
  input  logic              done_o,
  input  logic [BoardW-1:0] attack_set_o,
  output int                mismatch_count,
  output int                pending_count,
  output int                sets_checked
);

  timeunit 1ns;
  timeprecision 1ps;

  // leaper offsets as file and rank steps
  localparam int KingStepF[8]   = '{ 1,  1,  0, -1, -1, -1,  0,  1};
  localparam int KingStepR[8]   = '{ 0,  1,  1,  1,  0, -1, -1, -1};
  localparam int KnightStepF[8] = '{ 2,  1, -1, -2, -2, -1,  1,  2};
  localparam int KnightStepR[8] = '{ 1,  2,  2,  1, -1, -2, -2, -1};

  // ray directions, orthogonal then diagonal
  localparam int OrthStepF[4] = '{ 0,  0,  1, -1};
  localparam int OrthStepR[4] = '{ 1, -1,  0,  0};
  localparam int DiagStepF[4] = '{ 1, -1,  1, -1};
  localparam int DiagStepR[4] = '{ 1,  1, -1, -1};

  logic [BoardW-1:0] attack_sets_due[$];
  logic [BoardW-1:0] due_set;

  // king or knight target squares that stay on the board
  function automatic logic [BoardW-1:0] leap_targets(logic [SqW-1:0] sq, logic knight);
    logic [BoardW-1:0] hits;
    int                f;
    int                r;
    hits = '0;
    for (int i = 0; i < 8; i++) begin
      f = int'(sq[2:0]) + (knight ? KnightStepF[i] : KingStepF[i]);
      r = int'(sq[5:3]) + (knight ? KnightStepR[i] : KingStepR[i]);
      if (f >= 0 && f < 8 && r >= 0 && r < 8) hits[r * 8 + f] = 1'b1;
    end
    return hits;
  endfunction

  // walk each ray until it leaves the board or lands on an occupied square
  function automatic logic [BoardW-1:0] ray_cover(logic [SqW-1:0] sq,
                                                  logic [BoardW-1:0] occ, logic diag);
    logic [BoardW-1:0] reach;
    logic              blocked;
    int                f;
    int                r;
    int                df;
    int                dr;
    reach = '0;
    for (int d = 0; d < 4; d++) begin
      df      = diag ? DiagStepF[d] : OrthStepF[d];
      dr      = diag ? DiagStepR[d] : OrthStepR[d];
      f       = int'(sq[2:0]) + df;
      r       = int'(sq[5:3]) + dr;
      blocked = 1'b0;
      while (!blocked && f >= 0 && f < 8 && r >= 0 && r < 8) begin
        reach[r * 8 + f] = 1'b1;
        blocked          = occ[r * 8 + f];
        f                = f + df;
        r                = r + dr;
      end
    end
    return reach;
  endfunction

  // expected attack set of one query
  function automatic logic [BoardW-1:0] attack_set_of(logic [2:0] code, logic [SqW-1:0] sq,
                                                      logic [BoardW-1:0] occ,
                                                      logic [BoardW-1:0] blk);
    logic [BoardW-1:0] seen;
    logic [BoardW-1:0] answer;
    seen   = '0;
    answer = '0;
    case (code)
      CmdKing:   answer = leap_targets(sq, 1'b0);
      CmdKnight: answer = leap_targets(sq, 1'b1);
      CmdRook:   answer = ray_cover(sq, occ, 1'b0);
      CmdBishop: answer = ray_cover(sq, occ, 1'b1);
      CmdRookXray: begin
        seen   = ray_cover(sq, occ, 1'b0);
        answer = seen ^ ray_cover(sq, occ ^ (blk & seen), 1'b0);
      end
      CmdBishopXray: begin
        seen   = ray_cover(sq, occ, 1'b1);
        answer = seen ^ ray_cover(sq, occ ^ (blk & seen), 1'b1);
      end
      default: answer = '0;
    endcase
    return answer;
  endfunction

  // count a failure, print only the first ten
  task automatic flag_mismatch(string what, logic [BoardW-1:0] want, logic [BoardW-1:0] got);
    if (mismatch_count < 10) begin
      $display("%0t: %s: expected attack_set %016h, got %016h", $realtime, what, want, got);
    end
    mismatch_count = mismatch_count + 1;
  endtask

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    sets_checked   = 0;
  end

  // compare finished transactions first, then queue the one taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_sets_due.delete();
    end else begin
      if (done_o === 1'b1) begin
        if (attack_sets_due.size() == 0) begin
          flag_mismatch("result with no query waiting", '0, attack_set_o);
        end else begin
          due_set = attack_sets_due.pop_front();
          if (attack_set_o !== due_set) flag_mismatch("attack set mismatch", due_set,
                                                      attack_set_o);
          sets_checked = sets_checked + 1;
        end
      end
      if (start && !busy) begin
        attack_sets_due.push_back(attack_set_of(cmd_i, square_i, occupancy_i,
                                                xray_blockers_i));
      end
    end
    pending_count = attack_sets_due.size();
  end

endmodule

// File: test/bitboard_attack_generator_top_tb.sv
// testbench top for the attack generator: clock, reset, query stimulus and verdict
// depends on bba_pkg, bitboard_attack_generator_top and bitboard_attack_generator_checker
module bitboard_attack_generator_top_tb;

  import bba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // the two command codes the block leaves unused
  localparam logic [2:0] SpareCmdLo = 3'd6;
  localparam logic [2:0] SpareCmdHi = 3'd7;

  localparam logic [BoardW-1:0] EmptyBoard = '0;
  localparam logic [BoardW-1:0] FullBoard  = '1;

  localparam int RandomQueries = 1230;
  localparam int QuietLimit    = 5000;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [2:0]        cmd_i;
  logic [SqW-1:0]    square_i;
  logic [BoardW-1:0] occupancy_i;
  logic [BoardW-1:0] xray_blockers_i;
  logic              done_o;
  logic [BoardW-1:0] attack_set_o;

  int mismatch_count;
  int pending_count;
  int sets_checked;
  int quiet_cycles;
  int cmd_tally[8];
  int queries_sent;
  int no_gap_left;

  bitboard_attack_generator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .square_i       (square_i),
    .occupancy_i    (occupancy_i),
    .xray_blockers_i(xray_blockers_i),
    .done_o         (done_o),
    .attack_set_o   (attack_set_o)
  );

  bitboard_attack_generator_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .square_i       (square_i),
    .occupancy_i    (occupancy_i),
    .xray_blockers_i(xray_blockers_i),
    .done_o         (done_o),
    .attack_set_o   (attack_set_o),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .sets_checked   (sets_checked)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // watchdog on cycles where no transaction moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout after %0d idle cycles, %0d results outstanding", quiet_cycles,
               pending_count);
      $display("bitboard_attack_generator_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [BoardW-1:0] rand_board();
    return {$urandom(), $urandom()};
  endfunction

  // occupancy with a spread of densities, from empty to full
  function automatic logic [BoardW-1:0] occupancy_pattern();
    logic [BoardW-1:0] pat;
    case ($urandom_range(0, 9))
      0:       pat = EmptyBoard;
      1:       pat = FullBoard;
      2, 3:    pat = rand_board() & rand_board() & rand_board();
      4, 5:    pat = rand_board() & rand_board();
      6, 7:    pat = rand_board();
      8:       pat = rand_board() | rand_board();
      default: pat = EmptyBoard | (64'h1 << $urandom_range(0, 63));
    endcase
    return pat;
  endfunction

  // drive one query and hold it until the block takes it
  task automatic send_query(logic [2:0] code, logic [SqW-1:0] sq, logic [BoardW-1:0] occ,
                            logic [BoardW-1:0] blk);
    @(negedge clk_i);
    start           <= 1'b1;
    cmd_i           <= code;
    square_i        <= sq;
    occupancy_i     <= occ;
    xray_blockers_i <= blk;
    do @(posedge clk_i); while (busy);
    cmd_tally[code] = cmd_tally[code] + 1;
    queries_sent    = queries_sent + 1;
  endtask

  // idle for some cycles with junk on the payload
  task automatic idle_cycles(int n);
    if (n > 0) begin
      @(negedge clk_i);
      start           <= 1'b0;
      cmd_i           <= 3'($urandom());
      square_i        <= SqW'($urandom());
      occupancy_i     <= rand_board();
      xray_blockers_i <= rand_board();
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // mostly short gaps, some long ones, and runs with none at all
  task automatic random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gap_left > 0) begin
      no_gap_left = no_gap_left - 1;
    end else if (pick < 4) begin
      no_gap_left = $urandom_range(20, 80);
    end else if (pick < 55) begin
      idle_cycles(0);
    end else if (pick < 88) begin
      idle_cycles($urandom_range(1, 3));
    end else if (pick < 98) begin
      idle_cycles($urandom_range(4, 12));
    end else begin
      idle_cycles($urandom_range(20, 60));
    end
  endtask

  // hold off until every outstanding attack set has come back
  task automatic drain_results();
    idle_cycles(1);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [2:0]        code;
    logic [BoardW-1:0] occ;
    logic [BoardW-1:0] blk;
    int                pick;

    start           = 1'b0;
    cmd_i           = CmdKing;
    square_i        = '0;
    occupancy_i     = EmptyBoard;
    xray_blockers_i = EmptyBoard;
    rst_ni          = 1'b0;
    quiet_cycles    = 0;
    queries_sent    = 0;
    no_gap_left     = 0;
    foreach (cmd_tally[i]) cmd_tally[i] = 0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: corners, full and empty boards, ignored inputs, x-ray corner cases
    send_query(CmdKing, 6'd0, EmptyBoard, EmptyBoard);
    send_query(CmdKing, 6'd63, FullBoard, FullBoard);
    send_query(CmdKnight, 6'd7, EmptyBoard, EmptyBoard);
    send_query(CmdKnight, 6'd56, FullBoard, FullBoard);
    send_query(CmdKnight, 6'd27, rand_board(), rand_board());
    send_query(CmdRook, 6'd0, EmptyBoard, FullBoard);
    send_query(CmdRook, 6'd63, FullBoard, EmptyBoard);
    send_query(CmdBishop, 6'd27, EmptyBoard, FullBoard);
    send_query(CmdBishop, 6'd7, FullBoard, FullBoard);
    // origin square occupied, nothing else
    send_query(CmdRook, 6'd27, 64'h1 << 27, EmptyBoard);
    send_query(CmdBishop, 6'd36, 64'h1 << 36, FullBoard);
    send_query(CmdRookXray, 6'd0, FullBoard, FullBoard);
    send_query(CmdBishopXray, 6'd63, FullBoard, FullBoard);
    // blockers on empty squares get toggled into the occupancy
    send_query(CmdRookXray, 6'd27, EmptyBoard, FullBoard);
    send_query(CmdBishopXray, 6'd36, EmptyBoard, FullBoard);
    send_query(CmdRookXray, 6'd35, rand_board(), EmptyBoard);
    send_query(CmdBishopXray, 6'd28, rand_board() & rand_board(), rand_board());
    send_query(CmdRookXray, 6'd63, 64'h1 << 63, FullBoard);
    send_query(SpareCmdLo, 6'd27, FullBoard, FullBoard);
    send_query(SpareCmdHi, 6'd63, FullBoard, FullBoard);
    drain_results();

    // random queries, blockers mostly drawn from occupied squares
    for (int n = 0; n < RandomQueries; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        code = $urandom_range(0, 1) ? SpareCmdLo : SpareCmdHi;
      end else begin
        code = cmd_e'($urandom_range(CmdKing, CmdBishopXray));
      end
      occ  = occupancy_pattern();
      pick = $urandom_range(0, 9);
      if (pick < 6) blk = occ & rand_board();
      else if (pick < 8) blk = occupancy_pattern();
      else if (pick < 9) blk = occ;
      else blk = EmptyBoard;
      send_query(code, SqW'($urandom_range(0, 63)), occ, blk);
      if (n % 250 == 249) drain_results();
      else random_gap();
    end

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("covered %0d queries: king %0d, knight %0d, rook %0d, bishop %0d, "
             , queries_sent, cmd_tally[CmdKing], cmd_tally[CmdKnight],
             cmd_tally[CmdRook], cmd_tally[CmdBishop]);
    $display("rook x-ray %0d, bishop x-ray %0d, unused codes %0d; %0d attack sets checked",
             cmd_tally[CmdRookXray], cmd_tally[CmdBishopXray],
             cmd_tally[SpareCmdLo] + cmd_tally[SpareCmdHi], sets_checked);
    if (mismatch_count == 0) begin
      $display("bitboard_attack_generator_top regression: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("bitboard_attack_generator_top regression: fail");
    end
    $finish;
  end

endmodule
